/* rtl/srs_pkg.sv */
// ---------------------------------------------------------------------------
// srs_pkg: shared types and constants
// Query codes and the digit width of the pipelined multiplier cells.
// ---------------------------------------------------------------------------
package srs_pkg;

   localparam int DIGIT_WIDTH = 16;

   typedef enum logic {
      FUNC_RAY    = 1'b0,
      FUNC_SPHERE = 1'b1
   } func_type;

endpackage

/* rtl/srs_ifs.sv */
// ---------------------------------------------------------------------------
// srs_ifs: request and response channels
// Valid/ready channels carrying one query beat and one result beat.
// ---------------------------------------------------------------------------
interface srs_req_if
   import srs_pkg::*;
#(
   parameter int COORD_WIDTH = 32
);
   logic                          valid;
   logic                          ready;
   func_type                      func;
   logic signed [COORD_WIDTH-1:0] center_x;
   logic signed [COORD_WIDTH-1:0] center_y;
   logic signed [COORD_WIDTH-1:0] center_z;
   logic        [COORD_WIDTH-2:0] radius;
   logic signed [COORD_WIDTH-1:0] origin_x;
   logic signed [COORD_WIDTH-1:0] origin_y;
   logic signed [COORD_WIDTH-1:0] origin_z;
   logic signed [COORD_WIDTH-1:0] dir_x;
   logic signed [COORD_WIDTH-1:0] dir_y;
   logic signed [COORD_WIDTH-1:0] dir_z;
   logic        [COORD_WIDTH-2:0] other_radius;

   modport source (
      output valid, func, center_x, center_y, center_z, radius,
             origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, other_radius,
      input  ready
   );
   modport sink (
      input  valid, func, center_x, center_y, center_z, radius,
             origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, other_radius,
      output ready
   );
endinterface

interface srs_rsp_if
   import srs_pkg::*;
#(
   parameter int COORD_WIDTH = 32
);
   logic                          valid;
   logic                          ready;
   logic                          hit;
   logic signed [COORD_WIDTH-1:0] push_x;
   logic signed [COORD_WIDTH-1:0] push_y;
   logic signed [COORD_WIDTH-1:0] push_z;
   logic                          degenerate;

   modport source (
      output valid, hit, push_x, push_y, push_z, degenerate,
      input  ready
   );
   modport sink (
      input  valid, hit, push_x, push_y, push_z, degenerate,
      output ready
   );
endinterface

/* rtl/srs_mul_cell.sv */
// ---------------------------------------------------------------------------
// srs_mul_cell: one digit of a pipelined multiplier
// Multiplies the full A operand by one digit of B and adds the shifted
// partial product to the running sum handed on from the previous cell.
// ---------------------------------------------------------------------------
module srs_mul_cell
   import srs_pkg::*;
#(
   parameter int A_WIDTH = 66,
   parameter int B_WIDTH = 80,
   parameter int P_WIDTH = 132,
   parameter int INDEX   = 0
) (
   input  logic               clock,
   input  logic               enable,
   input  logic [A_WIDTH-1:0] a_up,
   input  logic [B_WIDTH-1:0] b_up,
   input  logic [P_WIDTH-1:0] acc_up,
   output logic [A_WIDTH-1:0] a_dn,
   output logic [B_WIDTH-1:0] b_dn,
   output logic [P_WIDTH-1:0] acc_dn
);

   localparam int SHIFT = INDEX * DIGIT_WIDTH;

   logic [DIGIT_WIDTH-1:0]         digit;
   logic [A_WIDTH+DIGIT_WIDTH-1:0] prod;
   logic [P_WIDTH-1:0]             part;
   logic [P_WIDTH-1:0]             acc_in;
   logic [A_WIDTH-1:0]             a_ff;
   logic [B_WIDTH-1:0]             b_ff;
   logic [P_WIDTH-1:0]             acc_ff;

   assign digit  = b_up[SHIFT +: DIGIT_WIDTH];
   assign prod   = a_up * digit;
   assign part   = P_WIDTH'(prod) << SHIFT;
   assign acc_in = acc_up + part;

   always_ff @(posedge clock) begin
      if (enable) begin
         a_ff   <= a_up;
         b_ff   <= b_up;
         acc_ff <= acc_in;
      end
   end

   assign a_dn   = a_ff;
   assign b_dn   = b_ff;
   assign acc_dn = acc_ff;

endmodule

/* rtl/srs_sqrt_cell.sv */
// ---------------------------------------------------------------------------
// srs_sqrt_cell: one bit of a pipelined integer square root
// Tries to set one root bit against the remainder n - root^2.
// ---------------------------------------------------------------------------
module srs_sqrt_cell #(
   parameter int N_WIDTH = 69,
   parameter int R_WIDTH = 34,
   parameter int BIT_POS = 0
) (
   input  logic               clock,
   input  logic               enable,
   input  logic [N_WIDTH-1:0] rem_up,
   input  logic [R_WIDTH-1:0] root_up,
   output logic [N_WIDTH-1:0] rem_dn,
   output logic [R_WIDTH-1:0] root_dn
);

   logic [N_WIDTH-1:0] trial;
   logic               take;
   logic [N_WIDTH-1:0] rem_in;
   logic [R_WIDTH-1:0] root_in;
   logic [N_WIDTH-1:0] rem_ff;
   logic [R_WIDTH-1:0] root_ff;

   // (root + 2^k)^2 - root^2, root holding only bits above k
   assign trial   = (N_WIDTH'(root_up) << (BIT_POS + 1)) + (N_WIDTH'(1) << (2 * BIT_POS));
   assign take    = rem_up >= trial;
   assign rem_in  = take ? rem_up - trial : rem_up;
   assign root_in = take ? (root_up | (R_WIDTH'(1) << BIT_POS)) : root_up;

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign rem_dn  = rem_ff;
   assign root_dn = root_ff;

endmodule

/* rtl/srs_div_cell.sv */
// ---------------------------------------------------------------------------
// srs_div_cell: one quotient bit of a pipelined restoring divider
// Shifts in one dividend bit and subtracts the divisor when it fits.
// ---------------------------------------------------------------------------
module srs_div_cell #(
   parameter int D_WIDTH = 34,
   parameter int Q_WIDTH = 32,
   parameter int BIT_POS = 0
) (
   input  logic               clock,
   input  logic               enable,
   input  logic [D_WIDTH-1:0] rem_up,
   input  logic [Q_WIDTH-1:0] quo_up,
   input  logic [Q_WIDTH-1:0] low_up,
   input  logic [D_WIDTH-1:0] den_up,
   output logic [D_WIDTH-1:0] rem_dn,
   output logic [Q_WIDTH-1:0] quo_dn,
   output logic [Q_WIDTH-1:0] low_dn,
   output logic [D_WIDTH-1:0] den_dn
);

   logic [D_WIDTH:0]   shifted;
   logic [D_WIDTH:0]   diff;
   logic               take;
   logic [D_WIDTH-1:0] rem_in;
   logic [Q_WIDTH-1:0] quo_in;
   logic [D_WIDTH-1:0] rem_ff;
   logic [Q_WIDTH-1:0] quo_ff;
   logic [Q_WIDTH-1:0] low_ff;
   logic [D_WIDTH-1:0] den_ff;

   assign shifted = {rem_up, low_up[BIT_POS]};
   assign diff    = shifted - {1'b0, den_up};
   assign take    = shifted >= {1'b0, den_up};
   assign rem_in  = take ? diff[D_WIDTH-1:0] : shifted[D_WIDTH-1:0];
   assign quo_in  = take ? (quo_up | (Q_WIDTH'(1) << BIT_POS)) : quo_up;

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         low_ff <= low_up;
         den_ff <= den_up;
      end
   end

   assign rem_dn = rem_ff;
   assign quo_dn = quo_ff;
   assign low_dn = low_ff;
   assign den_dn = den_ff;

endmodule

/* rtl/srs_skid.sv */
// ---------------------------------------------------------------------------
// srs_skid: output register with skid stage
// Decouples the pipeline enable from the downstream ready.
// ---------------------------------------------------------------------------
module srs_skid #(
   parameter type DATA_TYPE = logic [0:0]
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     up_valid,
   output logic     up_ready,
   input  DATA_TYPE up_data,
   output logic     dn_valid,
   input  logic     dn_ready,
   output DATA_TYPE dn_data
);

   logic     out_valid_ff, out_valid_in;
   logic     skid_valid_ff, skid_valid_in;
   DATA_TYPE out_data_ff, out_data_in;
   DATA_TYPE skid_data_ff, skid_data_in;

   assign up_ready = !skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (up_valid && up_ready) begin
         if (out_valid_ff && !dn_ready) begin
            // park the beat while the output waits
            skid_valid_in = 1'b1;
            skid_data_in  = up_data;
         end else begin
            out_valid_in = 1'b1;
            out_data_in  = up_data;
         end
      end else if (dn_ready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign dn_valid = out_valid_ff;
   assign dn_data  = out_data_ff;

endmodule

/* rtl/sphere_ray_and_sphere_collision.sv */
// ---------------------------------------------------------------------------
// Throughput: one query per cycle unless the response channel stalls; the row of
// square-root cells (one root bit each) and the three rows of divider cells
// (one quotient bit each) set the depth, every cell handing its partial result
// on whenever the pipeline advances.
// Reset clears the valid bits of all stages and the output register.
// ---------------------------------------------------------------------------
// sphere_ray_and_sphere_collision: ray/sphere and sphere/sphere tests
// Exact fixed-point hit decisions and a saturated separation vector.
// ---------------------------------------------------------------------------
module sphere_ray_and_sphere_collision
   import srs_pkg::*;
#(
   parameter int COORD_WIDTH = 32
) (
   input  logic          clock,
   input  logic          reset,
   srs_req_if.sink       req_chan,
   srs_rsp_if.source     rsp_chan
);

   localparam int W       = COORD_WIDTH;
   localparam int LW      = W + 1;
   localparam int MW      = 2 * W + 2;
   localparam int PW      = 2 * MW;
   localparam int NC      = (MW + DIGIT_WIDTH - 1) / DIGIT_WIDTH;
   localparam int BPW     = NC * DIGIT_WIDTH;
   localparam int NW      = 2 * W + 5;
   localparam int RW      = W + 2;
   localparam int SQ      = W + 2;
   localparam int NUMW    = 2 * W + 3;
   localparam int DLY     = 2 * W + 5;
   localparam int BIG_IDX = W + 4;

   typedef struct packed {
      logic                valid;
      func_type            func;
      logic [2:0][LW-1:0]  lmag;
      logic [2:0]          lneg;
      logic [2:0][W-1:0]   dmag;
      logic [2:0]          dneg;
      logic [W-2:0]        r1;
      logic [W-1:0]        sum;
   } s1_type;

   typedef struct packed {
      logic                 valid;
      func_type             func;
      logic [2:0][2*W-1:0]  dd;
      logic [2:0][2*W+1:0]  ll;
      logic [2:0][2*W-1:0]  dl;
      logic [2:0]           dlneg;
      logic [2*W-3:0]       rr;
      logic [2*W-1:0]       ss;
      logic [2:0][LW-1:0]   lmag;
      logic [2:0]           lneg;
      logic [W-1:0]         sum;
   } s2_type;

   typedef struct packed {
      logic                valid;
      func_type            func;
      logic [MW-1:0]       a;
      logic [MW-1:0]       l2;
      logic [MW-1:0]       pos;
      logic [MW-1:0]       negs;
      logic [2*W-3:0]      rr;
      logic [2*W-1:0]      ss;
      logic [2:0][LW-1:0]  lmag;
      logic [2:0]          lneg;
      logic [W-1:0]        sum;
   } s3_type;

   typedef struct packed {
      logic                valid;
      func_type            func;
      logic                a_zero;
      logic                le_rr;
      logic                neg_gt;
      logic                sph_lt;
      logic                n2zero;
      logic [MW-1:0]       m;
      logic [MW-1:0]       cval;
      logic [MW-1:0]       a;
      logic [MW-1:0]       l2;
      logic [2:0][LW-1:0]  lmag;
      logic [2:0]          lneg;
      logic [W-1:0]        sum;
   } s4_type;

   typedef struct packed {
      logic                valid;
      func_type            func;
      logic                a_zero;
      logic                le_rr;
      logic                neg_gt;
      logic                ray_ge;
      logic                sph_lt;
      logic                n2zero;
      logic [W-1:0]        sum;
      logic [2:0][LW-1:0]  lmag;
      logic [2:0]          lneg;
      logic [2:0]          pneg;
      logic [2:0]          big;
   } side_type;

   typedef struct packed {
      logic [RW-1:0] len;
      logic [RW-1:0] gmag;
      logic          gneg;
   } g_type;

   typedef struct packed {
      logic [2:0][NUMW-1:0] num;
      logic [2:0]           neg;
      logic [RW-1:0]        den;
   } p_type;

   typedef struct packed {
      logic [2:0][RW-1:0] rem;
      logic [2:0][W-1:0]  low;
      logic [RW-1:0]      den;
   } b_type;

   typedef struct packed {
      logic              hit;
      logic [2:0][W-1:0] push;
      logic              degenerate;
   } rsp_type;

   logic     adv;
   s1_type   s1_ff, s1_in;
   s2_type   s2_ff, s2_in;
   s3_type   s3_ff, s3_in;
   s4_type   s4_ff, s4_in;
   g_type    g_ff, g_in;
   p_type    p_ff, p_in;
   b_type    b_ff, b_in;
   side_type side_ff [DLY];
   side_type side_in [DLY];
   side_type last;
   rsp_type  fin, rsp_data;
   logic     fin_valid;

   logic signed [W-1:0] cen [3];
   logic signed [W-1:0] org [3];
   logic signed [W-1:0] dir [3];
   logic        [LW-1:0] ldiff [3];

   logic [MW-1:0]  mul_a   [2][NC+1];
   logic [BPW-1:0] mul_b   [2][NC+1];
   logic [PW-1:0]  mul_acc [2][NC+1];
   logic           ray_ge_w;

   logic [NW-1:0] sq_rem  [SQ+1];
   logic [RW-1:0] sq_root [SQ+1];

   logic [RW-1:0] dv_rem [3][W+1];
   logic [W-1:0]  dv_quo [3][W+1];
   logic [W-1:0]  dv_low [3][W+1];
   logic [RW-1:0] dv_den [3][W+1];

   logic [2:0]    big_w;
   logic [W+2:0]  gap;
   logic [W-1:0]  lim  [3];
   logic [W-1:0]  qsat [3];

   assign req_chan.ready = adv;

   assign cen[0] = req_chan.center_x;
   assign cen[1] = req_chan.center_y;
   assign cen[2] = req_chan.center_z;
   assign org[0] = req_chan.origin_x;
   assign org[1] = req_chan.origin_y;
   assign org[2] = req_chan.origin_z;
   assign dir[0] = req_chan.dir_x;
   assign dir[1] = req_chan.dir_y;
   assign dir[2] = req_chan.dir_z;

   // stage 1: offsets and magnitudes
   always_comb begin
      s1_in.valid = req_chan.valid;
      s1_in.func  = req_chan.func;
      for (int i = 0; i < 3; i++) begin
         ldiff[i]      = {org[i][W-1], org[i]} - {cen[i][W-1], cen[i]};
         s1_in.lneg[i] = ldiff[i][LW-1];
         s1_in.lmag[i] = ldiff[i][LW-1] ? (-ldiff[i]) : ldiff[i];
         s1_in.dneg[i] = dir[i][W-1];
         s1_in.dmag[i] = dir[i][W-1] ? (-dir[i]) : dir[i];
      end
      s1_in.r1  = req_chan.radius;
      s1_in.sum = {1'b0, req_chan.radius} + {1'b0, req_chan.other_radius};
   end

   // stage 2: products
   always_comb begin
      s2_in.valid = s1_ff.valid;
      s2_in.func  = s1_ff.func;
      for (int i = 0; i < 3; i++) begin
         s2_in.dd[i]    = s1_ff.dmag[i] * s1_ff.dmag[i];
         s2_in.ll[i]    = s1_ff.lmag[i] * s1_ff.lmag[i];
         s2_in.dl[i]    = s1_ff.dmag[i] * s1_ff.lmag[i];
         s2_in.dlneg[i] = s1_ff.dneg[i] ^ s1_ff.lneg[i];
      end
      s2_in.rr   = s1_ff.r1 * s1_ff.r1;
      s2_in.ss   = s1_ff.sum * s1_ff.sum;
      s2_in.lmag = s1_ff.lmag;
      s2_in.lneg = s1_ff.lneg;
      s2_in.sum  = s1_ff.sum;
   end

   // stage 3: dot products, signed d.l split into two sums
   always_comb begin
      s3_in.valid = s2_ff.valid;
      s3_in.func  = s2_ff.func;
      s3_in.a     = '0;
      s3_in.l2    = '0;
      s3_in.pos   = '0;
      s3_in.negs  = '0;
      for (int i = 0; i < 3; i++) begin
         s3_in.a  = s3_in.a + MW'(s2_ff.dd[i]);
         s3_in.l2 = s3_in.l2 + MW'(s2_ff.ll[i]);
         if (s2_ff.dlneg[i]) begin
            s3_in.negs = s3_in.negs + MW'(s2_ff.dl[i]);
         end else begin
            s3_in.pos = s3_in.pos + MW'(s2_ff.dl[i]);
         end
      end
      s3_in.rr   = s2_ff.rr;
      s3_in.ss   = s2_ff.ss;
      s3_in.lmag = s2_ff.lmag;
      s3_in.lneg = s2_ff.lneg;
      s3_in.sum  = s2_ff.sum;
   end

   // stage 4: decisions that need no wide product
   always_comb begin
      s4_in.valid  = s3_ff.valid;
      s4_in.func   = s3_ff.func;
      s4_in.a_zero = s3_ff.a == '0;
      s4_in.le_rr  = s3_ff.l2 <= MW'(s3_ff.rr);
      s4_in.neg_gt = s3_ff.negs > s3_ff.pos;
      s4_in.sph_lt = s3_ff.l2 < MW'(s3_ff.ss);
      s4_in.n2zero = s3_ff.l2 == '0;
      s4_in.m      = s3_ff.negs - s3_ff.pos;
      s4_in.cval   = s3_ff.l2 - MW'(s3_ff.rr);
      s4_in.a      = s3_ff.a;
      s4_in.l2     = s3_ff.l2;
      s4_in.lmag   = s3_ff.lmag;
      s4_in.lneg   = s3_ff.lneg;
      s4_in.sum    = s3_ff.sum;
   end

   // ray test: (d.l)^2 against a*c, one digit per cell
   assign mul_a[0][0]   = s4_ff.m;
   assign mul_b[0][0]   = BPW'(s4_ff.m);
   assign mul_acc[0][0] = '0;
   assign mul_a[1][0]   = s4_ff.a;
   assign mul_b[1][0]   = BPW'(s4_ff.cval);
   assign mul_acc[1][0] = '0;

   for (genvar ln = 0; ln < 2; ln++) begin : g_mul_lane
      for (genvar k = 0; k < NC; k++) begin : g_mul_cell
         srs_mul_cell #(
            .A_WIDTH (MW),
            .B_WIDTH (BPW),
            .P_WIDTH (PW),
            .INDEX   (k)
         ) u_cell (
            .clock  (clock),
            .enable (adv),
            .a_up   (mul_a[ln][k]),
            .b_up   (mul_b[ln][k]),
            .acc_up (mul_acc[ln][k]),
            .a_dn   (mul_a[ln][k+1]),
            .b_dn   (mul_b[ln][k+1]),
            .acc_dn (mul_acc[ln][k+1])
         );
      end
   end

   assign ray_ge_w = mul_acc[0][NC] >= mul_acc[1][NC];

   // sphere test: |delta| one root bit per cell
   assign sq_rem[0]  = NW'(s4_ff.l2);
   assign sq_root[0] = '0;

   for (genvar k = 0; k < SQ; k++) begin : g_sqrt
      srs_sqrt_cell #(
         .N_WIDTH (NW),
         .R_WIDTH (RW),
         .BIT_POS (SQ - 1 - k)
      ) u_cell (
         .clock   (clock),
         .enable  (adv),
         .rem_up  (sq_rem[k]),
         .root_up (sq_root[k]),
         .rem_dn  (sq_rem[k+1]),
         .root_dn (sq_root[k+1])
      );
   end

   // gap = len - (r1 + r2)
   always_comb begin
      gap       = {1'b0, sq_root[SQ]} - {3'b000, side_ff[SQ-1].sum};
      g_in.len  = sq_root[SQ];
      g_in.gneg = gap[W+2];
      g_in.gmag = gap[W+2] ? RW'(-gap) : RW'(gap);
   end

   // numerators |delta_i| * |gap|
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p_in.num[i] = side_ff[SQ].lmag[i] * g_ff.gmag;
         p_in.neg[i] = side_ff[SQ].lneg[i] ^ g_ff.gneg;
      end
      p_in.den = g_ff.len;
   end

   // quotients of 2^W or more saturate; otherwise the top bits start the divide
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         big_w[i]    = p_ff.num[i] >= {p_ff.den, {W{1'b0}}};
         b_in.rem[i] = p_ff.num[i][W+RW-1:W];
         b_in.low[i] = p_ff.num[i][W-1:0];
      end
      b_in.den = p_ff.den;
   end

   for (genvar ln = 0; ln < 3; ln++) begin : g_div_lane
      assign dv_rem[ln][0] = b_ff.rem[ln];
      assign dv_quo[ln][0] = '0;
      assign dv_low[ln][0] = b_ff.low[ln];
      assign dv_den[ln][0] = b_ff.den;
      for (genvar k = 0; k < W; k++) begin : g_div_cell
         srs_div_cell #(
            .D_WIDTH (RW),
            .Q_WIDTH (W),
            .BIT_POS (W - 1 - k)
         ) u_cell (
            .clock  (clock),
            .enable (adv),
            .rem_up (dv_rem[ln][k]),
            .quo_up (dv_quo[ln][k]),
            .low_up (dv_low[ln][k]),
            .den_up (dv_den[ln][k]),
            .rem_dn (dv_rem[ln][k+1]),
            .quo_dn (dv_quo[ln][k+1]),
            .low_dn (dv_low[ln][k+1]),
            .den_dn (dv_den[ln][k+1])
         );
      end
   end

   // side line: flags and operands that travel alongside the cell rows
   always_comb begin
      side_in[0].valid  = s4_ff.valid;
      side_in[0].func   = s4_ff.func;
      side_in[0].a_zero = s4_ff.a_zero;
      side_in[0].le_rr  = s4_ff.le_rr;
      side_in[0].neg_gt = s4_ff.neg_gt;
      side_in[0].ray_ge = 1'b0;
      side_in[0].sph_lt = s4_ff.sph_lt;
      side_in[0].n2zero = s4_ff.n2zero;
      side_in[0].sum    = s4_ff.sum;
      side_in[0].lmag   = s4_ff.lmag;
      side_in[0].lneg   = s4_ff.lneg;
      side_in[0].pneg   = '0;
      side_in[0].big    = '0;
      for (int k = 1; k < DLY; k++) begin
         side_in[k] = side_ff[k-1];
      end
      side_in[NC].ray_ge    = ray_ge_w;
      side_in[BIG_IDX].pneg = p_ff.neg;
      side_in[BIG_IDX].big  = big_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
         s2_ff.valid <= 1'b0;
         s3_ff.valid <= 1'b0;
         s4_ff.valid <= 1'b0;
         for (int k = 0; k < DLY; k++) begin
            side_ff[k].valid <= 1'b0;
         end
      end else if (adv) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
         g_ff  <= g_in;
         p_ff  <= p_in;
         b_ff  <= b_in;
         for (int k = 0; k < DLY; k++) begin
            side_ff[k] <= side_in[k];
         end
      end
   end

   // saturate, apply sign, pick the result of the query kind
   assign last = side_ff[DLY-1];

   always_comb begin
      fin = '0;
      for (int i = 0; i < 3; i++) begin
         lim[i]  = last.pneg[i] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
         qsat[i] = (last.big[i] || (dv_quo[i][W] > lim[i])) ? lim[i] : dv_quo[i][W];
      end
      if (last.func == FUNC_RAY) begin
         fin.degenerate = last.a_zero;
         fin.hit        = !last.a_zero && (last.le_rr || (last.neg_gt && last.ray_ge));
      end else begin
         fin.degenerate = last.n2zero;
         fin.hit        = !last.n2zero && last.sph_lt;
         if (!last.n2zero) begin
            for (int i = 0; i < 3; i++) begin
               fin.push[i] = last.pneg[i] ? (-qsat[i]) : qsat[i];
            end
         end
      end
   end

   assign fin_valid = last.valid;

   srs_skid #(
      .DATA_TYPE (rsp_type)
   ) u_skid (
      .clock    (clock),
      .reset    (reset),
      .up_valid (fin_valid),
      .up_ready (adv),
      .up_data  (fin),
      .dn_valid (rsp_chan.valid),
      .dn_ready (rsp_chan.ready),
      .dn_data  (rsp_data)
   );

   assign rsp_chan.hit        = rsp_data.hit;
   assign rsp_chan.push_x     = rsp_data.push[0];
   assign rsp_chan.push_y     = rsp_data.push[1];
   assign rsp_chan.push_z     = rsp_data.push[2];
   assign rsp_chan.degenerate = rsp_data.degenerate;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_chan.valid)
      else $error("response valid after reset");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> s1_ff.valid)
      else $error("accepted beat lost at first stage");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(side_ff[DLY-1]))
      else $error("pipeline moved while stalled");

   a_degen_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.degenerate |->
         !rsp_chan.hit && rsp_chan.push_x == '0 && rsp_chan.push_y == '0 &&
         rsp_chan.push_z == '0)
      else $error("degenerate result with hit or push");

endmodule
